/* design/pjq_pkg.sv */
// ----------------------------------------------------------------------------
// Priority job queue package
// Shared types and codes for the priority job queue and its cells.
// ----------------------------------------------------------------------------
package pjq_pkg;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_OK  = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd3;

    typedef struct packed {
        logic [15:0] job_id;
        logic [7:0]  prio;
        logic        cancelled;
    } entry_t;

    // Broadcast from the top level to every cell, already qualified by the beat.
    typedef struct packed {
        logic        rewrite_en;
        logic        cancel_en;
        logic        insert_en;
        logic        pop_en;
        logic [15:0] job_id;
        logic [7:0]  prio;
    } cell_req_t;

endpackage

/* design/pjq_req_if.sv */
// ----------------------------------------------------------------------------
// Priority job queue request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface pjq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] job_id;
    logic [7:0]  priority_req;
    logic [1:0]  job_mode;
    logic        job_idle;

    modport source (
        output valid, command, job_id, priority_req, job_mode, job_idle,
        input  ready
    );
    modport sink (
        input  valid, command, job_id, priority_req, job_mode, job_idle,
        output ready
    );
endinterface

/* design/pjq_rsp_if.sv */
// ----------------------------------------------------------------------------
// Priority job queue response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface pjq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        served_valid;
    logic [15:0] served_job_id;
    logic        dropped;

    modport source (
        output valid, status, served_valid, served_job_id, dropped,
        input  ready
    );
    modport sink (
        input  valid, status, served_valid, served_job_id, dropped,
        output ready
    );
endinterface

/* design/priority_job_queue_with_cancel.sv */
// ----------------------------------------------------------------------------
// Priority job queue with cancel
// Sorted job queue, highest priority at the head, built as a row of cells.
// ----------------------------------------------------------------------------
// The req channel takes one command per beat: submit, cancel or service tick.
// The rsp channel returns exactly one result beat for every command beat,
// in order. A command is decided in the cycle it is accepted: every cell
// compares its entry with the request in parallel, a first-match chain
// through the row picks the hit and the insert position, and the cells
// shift or load their entries at that edge. The result is registered and
// appears in the cycle after the command beat, and a command can be
// accepted every cycle as long as the receiver keeps taking results. The
// depth of the first-match chain, one step per cell, sets the cycle time.
// When the receiver stalls, the result register holds and req ready drops
// until the result is taken. Reset empties the queue at once; no clearing
// pass is needed, since the fill count marks which cells are held.
// ----------------------------------------------------------------------------
module priority_job_queue_with_cancel #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    pjq_req_if.sink   req,
    pjq_rsp_if.source rsp
);
    import pjq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic             served_reg;
    logic             served_next;
    logic [15:0]      served_id_reg;
    logic [15:0]      served_id_next;
    logic             dropped_reg;
    logic             dropped_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             rejected;
    logic             hit_any;
    cell_req_t        creq;

    logic   [QUEUE_DEPTH-1:0] occ;
    logic   [QUEUE_DEPTH:0]   hit_chain;
    logic   [QUEUE_DEPTH:0]   ins_chain;
    entry_t [QUEUE_DEPTH-1:0] eff;
    entry_t [QUEUE_DEPTH-1:0] ent;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign rejected  = req.job_idle && (req.job_mode != MODE_SINGLE);
    assign hit_any   = hit_chain[QUEUE_DEPTH];

    always_comb
    begin
        creq.job_id     = req.job_id;
        creq.prio       = req.priority_req;
        creq.rewrite_en = accept && (req.command == CMD_SUBMIT)
                          && ((req.job_mode == MODE_START) || (req.job_mode == MODE_SINGLE));
        creq.cancel_en  = accept && (req.command == CMD_CANCEL);
        creq.insert_en  = accept && (req.command == CMD_SUBMIT) && !rejected && !full;
        creq.pop_en     = accept && (req.command == CMD_TICK) && !empty;
    end

    assign hit_chain[0] = 1'b0;
    assign ins_chain[0] = 1'b0;

    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(k);
        entry_t left_eff;
        entry_t right_ent;
        logic   left_occ;

        assign occ[k] = (IDX < count_reg);

        if (k == 0)
        begin : g_first
            assign left_eff = '0;
            assign left_occ = 1'b0;
        end
        else
        begin : g_mid
            assign left_eff = eff[k-1];
            assign left_occ = occ[k-1];
        end

        if (k == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_ent = '0;
        end
        else
        begin : g_inner
            assign right_ent = ent[k+1];
        end

        pjq_cell u_cell (
            .clk       (clk),
            .req       (creq),
            .occ       (occ[k]),
            .left_occ  (left_occ),
            .left_eff  (left_eff),
            .right_ent (right_ent),
            .hit_in    (hit_chain[k]),
            .ins_in    (ins_chain[k]),
            .hit_out   (hit_chain[k+1]),
            .ins_out   (ins_chain[k+1]),
            .eff       (eff[k]),
            .ent       (ent[k])
        );
    end

    always_comb
    begin
        status_next    = ST_OK;
        served_next    = 1'b0;
        served_id_next = '0;
        dropped_next   = 1'b0;
        count_next     = count_reg;
        unique case (req.command)
            CMD_SUBMIT:
            begin
                if (rejected)
                begin
                    status_next = ST_NOT_OK;
                end
                else if (full)
                begin
                    status_next = ST_BUSY;
                end
            end
            CMD_CANCEL:
            begin
                status_next = hit_any ? ST_OK : ST_NOT_OK;
            end
            CMD_TICK:
            begin
                if (!empty)
                begin
                    dropped_next   = ent[0].cancelled;
                    served_next    = !ent[0].cancelled;
                    served_id_next = ent[0].cancelled ? 16'd0 : ent[0].job_id;
                end
            end
            default:
            begin
                status_next = ST_NOT_OK;
            end
        endcase
        if (creq.insert_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (creq.pop_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            served_reg    <= served_next;
            served_id_reg <= served_id_next;
            dropped_reg   <= dropped_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.served_valid  = served_reg;
    assign rsp.served_job_id = served_id_reg;
    assign rsp.dropped       = dropped_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Queue fill count exceeds the depth.");

    a_served_xor_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(served_reg && dropped_reg))
        else $error("A tick both served and dropped the head.");

    a_tick_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.command == CMD_TICK) && !empty) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("A tick on a held queue did not remove the head.");

    a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !served_reg) |-> (served_id_reg == 16'd0))
        else $error("Served job id is set without a dispatch.");

endmodule

/* design/pjq_cell.sv */
// ----------------------------------------------------------------------------
// Priority job queue cell
// Holds one queue entry; rewrites, cancels, loads or shifts it each beat.
// ----------------------------------------------------------------------------
module pjq_cell (
    input  logic              clk,
    input  pjq_pkg::cell_req_t req,
    input  logic              occ,
    input  logic              left_occ,
    input  pjq_pkg::entry_t   left_eff,
    input  pjq_pkg::entry_t   right_ent,
    input  logic              hit_in,
    input  logic              ins_in,
    output logic              hit_out,
    output logic              ins_out,
    output pjq_pkg::entry_t   eff,
    output pjq_pkg::entry_t   ent
);
    import pjq_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    entry_t new_ent;
    logic   first_hit;
    logic   greater;
    logic   at_pos;

    always_comb
    begin
        first_hit = occ && !hit_in && (ent_reg.job_id == req.job_id);
        hit_out   = hit_in || (occ && (ent_reg.job_id == req.job_id));

        new_ent.job_id    = req.job_id;
        new_ent.prio      = req.prio;
        new_ent.cancelled = 1'b0;

        // The rewritten priority is what the insert compares against.
        eff = (first_hit && req.rewrite_en) ? new_ent : ent_reg;

        greater = occ && (req.prio > eff.prio);
        at_pos  = !ins_in && (greater || !occ);
        ins_out = ins_in || greater || !occ;

        ent_next = eff;
        priority if (req.pop_en)
        begin
            ent_next = right_ent;
        end
        else if (req.insert_en && at_pos)
        begin
            ent_next = new_ent;
        end
        else if (req.insert_en && ins_in && left_occ)
        begin
            ent_next = left_eff;
        end
        else if (req.cancel_en && first_hit)
        begin
            ent_next.cancelled = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Priority job queue testbench
// Drives submit, cancel and service tick beats into the job queue and
// checks every result beat against a cycle-free model of the sorted queue,
// with random gaps on both channels, two long receiver stalls and drain pauses.
// ----------------------------------------------------------------------------
module tb;

    import pjq_pkg::*;

    localparam int QDEPTH = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 850;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    typedef struct {
        logic [1:0]  command;
        logic [15:0] job_id;
        logic [7:0]  prio;
        logic [1:0]  mode;
        logic        idle;
        int unsigned gap;
        bit          drain;
    } job_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        served_valid;
        logic [15:0] served_job_id;
        logic        dropped;
    } job_result_t;

    logic clk;
    logic rst_n;

    pjq_req_if req_ch ();
    pjq_rsp_if rsp_ch ();

    priority_job_queue_with_cancel #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    job_beat_t   pending_beats[$];
    job_result_t results_due[$];
    entry_t      queue_slots[QDEPTH];
    int          queue_fill;
    int          results_outstanding;
    int          errors;
    int          checked;
    int          cycles;
    int unsigned gap_count;
    int unsigned stall_left;
    int          rsp_beats;
    bit          drain_next;
    job_beat_t   next_beat;
    logic [15:0] id_pool[8];

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 checked, what, got, want);
    endtask

    task automatic add_beat(input logic [1:0] command, input logic [15:0] job_id,
                            input logic [7:0] prio, input logic [1:0] mode,
                            input logic idle, input int unsigned gap);
        job_beat_t b;
        b.command = command;
        b.job_id  = job_id;
        b.prio    = prio;
        b.mode    = mode;
        b.idle    = idle;
        b.gap     = gap;
        b.drain   = drain_next;
        drain_next = 1'b0;
        pending_beats.push_back(b);
    endtask

    function automatic job_result_t apply_command(input job_beat_t b);
        job_result_t r;
        int hit;
        int pos;
        int k;
        r = '0;
        r.status = ST_OK;
        hit = -1;
        for (k = 0; k < queue_fill; k++)
        begin
            if (hit < 0 && queue_slots[k].job_id == b.job_id)
                hit = k;
        end
        case (b.command)
            CMD_SUBMIT:
            begin
                if (hit >= 0 && (b.mode == MODE_START || b.mode == MODE_SINGLE))
                begin
                    queue_slots[hit].prio = b.prio;
                    queue_slots[hit].cancelled = 1'b0;
                end
                if (b.idle && b.mode != MODE_SINGLE)
                    r.status = ST_NOT_OK;
                else if (queue_fill >= QDEPTH)
                    r.status = ST_BUSY;
                else
                begin
                    pos = queue_fill;
                    for (k = queue_fill - 1; k >= 0; k--)
                    begin
                        if (b.prio > queue_slots[k].prio)
                            pos = k;
                    end
                    for (k = queue_fill; k > pos; k--)
                        queue_slots[k] = queue_slots[k - 1];
                    queue_slots[pos].job_id = b.job_id;
                    queue_slots[pos].prio = b.prio;
                    queue_slots[pos].cancelled = 1'b0;
                    queue_fill++;
                end
            end
            CMD_CANCEL:
            begin
                if (hit >= 0)
                    queue_slots[hit].cancelled = 1'b1;
                else
                    r.status = ST_NOT_OK;
            end
            CMD_TICK:
            begin
                if (queue_fill > 0)
                begin
                    if (queue_slots[0].cancelled)
                        r.dropped = 1'b1;
                    else
                    begin
                        r.served_valid = 1'b1;
                        r.served_job_id = queue_slots[0].job_id;
                    end
                    for (k = 1; k < queue_fill; k++)
                        queue_slots[k - 1] = queue_slots[k];
                    queue_fill--;
                end
            end
            default:
            begin
                r.status = ST_NOT_OK;
            end
        endcase
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sender: offers the next pending beat after its gap, or holds back at a
    // drain mark until every outstanding result has come back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.command      <= CMD_SUBMIT;
            req_ch.job_id       <= '0;
            req_ch.priority_req <= '0;
            req_ch.job_mode     <= MODE_START;
            req_ch.job_idle     <= 1'b0;
            gap_count = 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_beats.size() == 0)
                req_ch.valid <= 1'b0;
            else if (pending_beats[0].drain && (results_outstanding != 0 || req_ch.valid))
                req_ch.valid <= 1'b0;
            else if (gap_count < pending_beats[0].gap)
            begin
                gap_count++;
                req_ch.valid <= 1'b0;
            end
            else
            begin
                next_beat = pending_beats.pop_front();
                gap_count = 0;
                req_ch.valid        <= 1'b1;
                req_ch.command      <= next_beat.command;
                req_ch.job_id       <= next_beat.job_id;
                req_ch.priority_req <= next_beat.prio;
                req_ch.job_mode     <= next_beat.mode;
                req_ch.job_idle     <= next_beat.idle;
            end
        end
    end

    // Receiver: random stall per beat, calm stretches, and two long holds
    // that back the queue up into the request channel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
            rsp_beats = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_beats++;
                if (rsp_beats == 300 || rsp_beats == 650)
                    stall_left = 60;
                else if (rsp_beats % 200 < 40 || $urandom_range(0, 1) == 0)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 11);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        job_result_t want;
        job_beat_t   taken;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result beat with nothing outstanding",
                                    rsp_ch.served_job_id, '0);
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", 16'(rsp_ch.status), 16'(want.status));
                    if (rsp_ch.served_valid !== want.served_valid)
                        report_mismatch("served_valid", 16'(rsp_ch.served_valid),
                                        16'(want.served_valid));
                    if (rsp_ch.served_job_id !== want.served_job_id)
                        report_mismatch("served_job_id", rsp_ch.served_job_id,
                                        want.served_job_id);
                    if (rsp_ch.dropped !== want.dropped)
                        report_mismatch("dropped", 16'(rsp_ch.dropped), 16'(want.dropped));
                end
                checked++;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                taken.command = req_ch.command;
                taken.job_id  = req_ch.job_id;
                taken.prio    = req_ch.priority_req;
                taken.mode    = req_ch.job_mode;
                taken.idle    = req_ch.job_idle;
                taken.gap     = 0;
                taken.drain   = 1'b0;
                results_due.push_back(apply_command(taken));
            end
            results_outstanding <= results_due.size();
        end
    end

    initial
    begin : stimulus
        int n;
        int pick;
        logic [1:0]  cmd;
        logic [15:0] id;
        logic [7:0]  prio;
        int unsigned gap;
        errors = 0;
        checked = 0;
        cycles = 0;
        queue_fill = 0;
        results_outstanding = 0;
        drain_next = 1'b0;
        rst_n = 1'b0;

        add_beat(CMD_TICK, 16'h0000, 8'h00, MODE_START, 1'b0, 0);
        add_beat(CMD_CANCEL, 16'h0000, 8'h00, MODE_START, 1'b0, 0);
        add_beat(CMD_SUBMIT, 16'hFFFF, 8'hFF, MODE_START, 1'b0, 0);
        add_beat(CMD_SUBMIT, 16'h0000, 8'h00, MODE_FINISH, 1'b0, 0);
        add_beat(CMD_SUBMIT, 16'h1234, 8'h80, MODE_UPDATE, 1'b0, 1);
        add_beat(CMD_SUBMIT, 16'h5678, 8'h80, MODE_SINGLE, 1'b1, 0);
        add_beat(CMD_SUBMIT, 16'hAAAA, 8'h10, MODE_START, 1'b0, 0);
        add_beat(CMD_SUBMIT, 16'h1234, 8'h00, MODE_START, 1'b1, 2);
        add_beat(CMD_SUBMIT, 16'h0000, 8'hFF, MODE_SINGLE, 1'b0, 0);
        add_beat(CMD_CANCEL, 16'hFFFF, 8'h00, MODE_START, 1'b0, 0);
        add_beat(CMD_CANCEL, 16'hFFFF, 8'h00, MODE_START, 1'b0, 0);
        add_beat(CMD_UNKNOWN, 16'hFFFF, 8'hFF, MODE_SINGLE, 1'b1, 0);
        add_beat(CMD_TICK, 16'h0000, 8'h00, MODE_START, 1'b0, 3);
        add_beat(CMD_SUBMIT, 16'hFFFF, 8'h7F, MODE_UPDATE, 1'b0, 0);
        add_beat(CMD_SUBMIT, 16'h5678, 8'h01, MODE_UPDATE, 1'b1, 0);
        add_beat(CMD_SUBMIT, 16'h0000, 8'h01, MODE_FINISH, 1'b1, 0);
        add_beat(CMD_CANCEL, 16'h5678, 8'h00, MODE_START, 1'b0, 0);
        add_beat(CMD_SUBMIT, 16'h5678, 8'h90, MODE_START, 1'b0, 0);
        for (n = 0; n < 5; n++)
            add_beat(CMD_TICK, 16'h0000, 8'h00, MODE_START, 1'b0, 0);
        add_beat(CMD_SUBMIT, 16'h00FF, 8'h40, MODE_START, 1'b0, 0);
        add_beat(CMD_SUBMIT, 16'h00FF, 8'h40, MODE_START, 1'b0, 0);
        add_beat(CMD_CANCEL, 16'h00FF, 8'h00, MODE_START, 1'b0, 0);
        add_beat(CMD_TICK, 16'h0000, 8'h00, MODE_START, 1'b0, 0);
        add_beat(CMD_TICK, 16'h0000, 8'h00, MODE_START, 1'b0, 0);
        drain_next = 1'b1;

        for (n = 0; n < 8; n++)
            id_pool[n] = (n == 0) ? 16'h0000 : (n == 1) ? 16'hFFFF : 16'($urandom);

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 150 == 149)
                drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            cmd = (pick < 45) ? CMD_SUBMIT : (pick < 65) ? CMD_CANCEL :
                  (pick < 95) ? CMD_TICK : CMD_UNKNOWN;
            id = ($urandom_range(0, 4) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
            pick = $urandom_range(0, 9);
            prio = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
                   (pick < 5) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            if (n % 200 < 30 || $urandom_range(0, 1) == 0)
                gap = 0;
            else
                gap = $urandom_range(0, 11);
            add_beat(cmd, id, prio, 2'($urandom_range(0, 3)),
                     ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0, gap);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_beats.size() != 0 || req_ch.valid || results_outstanding != 0
               || results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (results_due.size() != 0)
            report_mismatch("results never returned", 16'(results_due.size()), '0);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
design/pjq_pkg.sv
design/pjq_req_if.sv
design/pjq_rsp_if.sv
design/pjq_cell.sv
design/priority_job_queue_with_cancel.sv
bench/tb.sv
